>>> hdl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the per-tenant LFU page table.
// ----------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

    localparam int NSLOTS  = 256;
    localparam int IDX_W   = 8;
    localparam int LOC_W   = 9;
    localparam int CNT_W   = 16;
    localparam int TENANTS = 8;
    localparam int TIX_W   = 3;
    localparam int TEN_W   = 4;
    localparam int PAGE_W  = 32;
    localparam int STAMP_W = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 3;

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_TOUCH  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_EVICT  = 3'd3;
    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_ABSENT   = 3'd1;
    localparam logic [ST_W-1:0] ST_PRESENT  = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOFREE   = 3'd4;
    localparam logic [ST_W-1:0] ST_OCCUPIED = 3'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TIX_W-1:0]   tix;
        logic [PAGE_W-1:0]  page;
        logic [LOC_W-1:0]   loc;
        logic [STAMP_W-1:0] stamp;
    } t_cmd;

    typedef struct packed {
        logic               vld;
        logic               hit;
        logic               occ;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   cnt;
        logic [STAMP_W-1:0] age;
        logic [PAGE_W-1:0]  page;
    } t_cand;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_commit;

endpackage

`default_nettype wire

>>> hdl/plt_if.sv
// ----------------------------------------------------------------------------
// plt_in_if / plt_out_if
// Valid/ready channels for requests and results of the page table.
// ----------------------------------------------------------------------------
`default_nettype none

interface plt_in_if;
    logic                      valid;
    logic                      ready;
    logic [plt_pkg::OP_W-1:0]  op;
    logic [plt_pkg::TEN_W-1:0] tenant;
    logic [plt_pkg::PAGE_W-1:0] page_id;
    logic [plt_pkg::LOC_W-1:0] location;

    modport source (output valid, op, tenant, page_id, location, input ready);
    modport sink   (input valid, op, tenant, page_id, location, output ready);
endinterface

interface plt_out_if;
    logic                       valid;
    logic                       ready;
    logic [plt_pkg::ST_W-1:0]   status;
    logic                       found;
    logic [plt_pkg::LOC_W-1:0]  result_location;
    logic [plt_pkg::PAGE_W-1:0] victim_page;

    modport source (output valid, status, found, result_location, victim_page, input ready);
    modport sink   (input valid, status, found, result_location, victim_page, output ready);
endinterface

`default_nettype wire

>>> hdl/plt_cell.sv
// ----------------------------------------------------------------------------
// plt_cell
// One slot of the table; merges its entry into the candidate passing by.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [plt_pkg::IDX_W-1:0]  i_idx,
    input  wire plt_pkg::t_cmd              i_cmd,
    input  wire plt_pkg::t_cand             i_cand,
    input  wire plt_pkg::t_commit           i_commit,
    output plt_pkg::t_cand                  o_cand
);

    logic                         r_valid;
    logic [plt_pkg::TIX_W-1:0]    r_tix;
    logic [plt_pkg::PAGE_W-1:0]   r_page;
    logic [plt_pkg::CNT_W-1:0]    r_cnt;
    logic [plt_pkg::STAMP_W-1:0]  r_stamp;
    plt_pkg::t_cand               r_cand;
    plt_pkg::t_cand               n_cand;
    logic [plt_pkg::STAMP_W-1:0]  w_age;
    logic                         w_own;
    logic                         w_sel;

    assign w_age = i_cmd.stamp - r_stamp;
    assign w_own = r_valid && (r_tix == i_cmd.tix);

    always_comb begin
        n_cand = i_cand;
        w_sel  = 1'b0;
        if (i_cmd.op == plt_pkg::OP_EVICT) begin
            w_sel = w_own && (!i_cand.hit || (r_cnt < i_cand.cnt) ||
                    ((r_cnt == i_cand.cnt) && (w_age > i_cand.age)));
        end else begin
            w_sel = w_own && (r_page == i_cmd.page) && !i_cand.hit;
        end
        if (w_sel) begin
            n_cand.hit  = 1'b1;
            n_cand.idx  = i_idx;
            n_cand.cnt  = r_cnt;
            n_cand.age  = w_age;
            n_cand.page = r_page;
        end
        if (({1'b0, i_idx} + 9'd1) == i_cmd.loc) begin
            n_cand.occ = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else begin
            r_cand <= n_cand;
        end
    end

    assign o_cand = r_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_commit.en && (i_commit.idx == i_idx)) begin
            case (i_cmd.op)
                plt_pkg::OP_INSERT: begin
                    r_valid <= 1'b1;
                end
                plt_pkg::OP_EVICT: begin
                    r_valid <= 1'b0;
                end
                default: begin
                    r_valid <= r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit.en && (i_commit.idx == i_idx)) begin
            case (i_cmd.op)
                plt_pkg::OP_INSERT: begin
                    r_tix   <= i_cmd.tix;
                    r_page  <= i_cmd.page;
                    r_cnt   <= plt_pkg::CNT_W'(1);
                    r_stamp <= i_cmd.stamp;
                end
                plt_pkg::OP_TOUCH: begin
                    if (r_cnt != plt_pkg::CNT_MAX) begin
                        r_cnt <= r_cnt + plt_pkg::CNT_W'(1);
                    end
                    r_stamp <= i_cmd.stamp;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/per_tenant_lfu_page_table.sv
// ----------------------------------------------------------------------------
// per_tenant_lfu_page_table
// Per-tenant page table with least-frequently-used eviction, oldest first.
// ----------------------------------------------------------------------------
// One request is handled at a time. Lookup, touch, insert and evict send a
// search wave down a chain of 256 slot cells, one cell per cycle; result valid
// rises once the wave has left the last cell. Allocate and unused op codes
// raise result valid in the cycle after the transfer. The next request is
// taken once the result has been transferred out.
`default_nettype none

module per_tenant_lfu_page_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plt_in_if.sink     i_in,
    plt_out_if.source  o_out
);

    plt_pkg::t_state                r_state;
    plt_pkg::t_state                n_state;
    plt_pkg::t_cmd                  r_cmd;
    logic                           r_start;
    logic [plt_pkg::STAMP_W-1:0]    r_stamp_ctr;
    logic [plt_pkg::LOC_W-1:0]      r_next_free;
    logic [plt_pkg::ST_W-1:0]       r_status;
    logic                           r_found;
    logic [plt_pkg::LOC_W-1:0]      r_rloc;
    logic [plt_pkg::PAGE_W-1:0]     r_victim;

    logic [plt_pkg::ST_W-1:0]       n_status;
    logic                           n_found;
    logic [plt_pkg::LOC_W-1:0]      n_rloc;
    logic [plt_pkg::PAGE_W-1:0]     n_victim;
    logic                           w_bump;
    logic                           w_alloc;
    logic                           w_take;
    logic                           w_done;
    logic                           w_scan_op;
    logic [plt_pkg::TEN_W-1:0]      w_tm1;
    plt_pkg::t_commit               w_commit;
    plt_pkg::t_cand                 w_cand [0:plt_pkg::NSLOTS];
    plt_pkg::t_cand                 w_last;

    assign w_take    = i_in.valid && i_in.ready;
    assign w_scan_op = (i_in.op == plt_pkg::OP_LOOKUP) || (i_in.op == plt_pkg::OP_TOUCH) ||
                       (i_in.op == plt_pkg::OP_INSERT) || (i_in.op == plt_pkg::OP_EVICT);
    assign w_tm1     = i_in.tenant - plt_pkg::TEN_W'(1);

    always_comb begin
        w_cand[0]     = '0;
        w_cand[0].vld = r_start;
    end

    for (genvar g = 0; g < plt_pkg::NSLOTS; g++) begin : g_cell
        plt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (plt_pkg::IDX_W'(g)),
            .i_cmd    (r_cmd),
            .i_cand   (w_cand[g]),
            .i_commit (w_commit),
            .o_cand   (w_cand[g+1])
        );
    end

    assign w_last = w_cand[plt_pkg::NSLOTS];
    assign w_done = (r_state == plt_pkg::S_SCAN) && w_last.vld;

    always_comb begin
        n_state   = r_state;
        n_status  = plt_pkg::ST_OK;
        n_found   = 1'b0;
        n_rloc    = '0;
        n_victim  = '0;
        w_bump    = 1'b0;
        w_alloc   = 1'b0;
        w_commit  = '0;
        case (r_state)
            plt_pkg::S_IDLE: begin
                if (w_take) begin
                    if (w_scan_op) begin
                        n_state = plt_pkg::S_SCAN;
                    end else begin
                        n_state = plt_pkg::S_OUT;
                        if (i_in.op == plt_pkg::OP_ALLOC) begin
                            if (r_next_free > plt_pkg::LOC_W'(plt_pkg::NSLOTS)) begin
                                n_status = plt_pkg::ST_NOFREE;
                            end else begin
                                n_rloc  = r_next_free;
                                w_alloc = 1'b1;
                            end
                        end
                    end
                end
            end
            plt_pkg::S_SCAN: begin
                if (w_done) begin
                    n_state = plt_pkg::S_OUT;
                    case (r_cmd.op)
                        plt_pkg::OP_LOOKUP: begin
                            if (w_last.hit) begin
                                n_found = 1'b1;
                                n_rloc  = {1'b0, w_last.idx} + 9'd1;
                            end else begin
                                n_status = plt_pkg::ST_ABSENT;
                            end
                        end
                        plt_pkg::OP_TOUCH: begin
                            if (w_last.hit) begin
                                n_rloc       = {1'b0, w_last.idx} + 9'd1;
                                w_commit.en  = 1'b1;
                                w_commit.idx = w_last.idx;
                                w_bump       = 1'b1;
                            end else begin
                                n_status = plt_pkg::ST_ABSENT;
                            end
                        end
                        plt_pkg::OP_INSERT: begin
                            if (w_last.hit) begin
                                n_status = plt_pkg::ST_PRESENT;
                            end else if ((r_cmd.loc == '0) ||
                                         (r_cmd.loc > plt_pkg::LOC_W'(plt_pkg::NSLOTS))) begin
                                n_status = plt_pkg::ST_NOFREE;
                            end else if (w_last.occ) begin
                                n_status = plt_pkg::ST_OCCUPIED;
                            end else begin
                                n_rloc       = r_cmd.loc;
                                w_commit.en  = 1'b1;
                                w_commit.idx = plt_pkg::IDX_W'(r_cmd.loc - 9'd1);
                                w_bump       = 1'b1;
                            end
                        end
                        plt_pkg::OP_EVICT: begin
                            if (w_last.hit) begin
                                n_rloc       = {1'b0, w_last.idx} + 9'd1;
                                n_victim     = w_last.page;
                                w_commit.en  = 1'b1;
                                w_commit.idx = w_last.idx;
                            end else begin
                                n_status = plt_pkg::ST_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            plt_pkg::S_OUT: begin
                if (o_out.ready) begin
                    n_state = plt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plt_pkg::S_IDLE;
            r_start     <= 1'b0;
            r_stamp_ctr <= '0;
            r_next_free <= plt_pkg::LOC_W'(1);
        end else begin
            r_state <= n_state;
            r_start <= w_take && w_scan_op;
            if (w_bump) begin
                r_stamp_ctr <= r_stamp_ctr + plt_pkg::STAMP_W'(1);
            end
            if (w_alloc) begin
                r_next_free <= r_next_free + plt_pkg::LOC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd.op    <= i_in.op;
            r_cmd.tix   <= plt_pkg::TIX_W'(w_tm1 % plt_pkg::TENANTS);
            r_cmd.page  <= i_in.page_id;
            r_cmd.loc   <= i_in.location;
        end
        r_cmd.stamp <= r_stamp_ctr;
        if (n_state == plt_pkg::S_OUT && r_state != plt_pkg::S_OUT) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_rloc   <= n_rloc;
            r_victim <= n_victim;
        end
    end

    assign i_in.ready            = (r_state == plt_pkg::S_IDLE);
    assign o_out.valid           = (r_state == plt_pkg::S_OUT);
    assign o_out.status          = r_status;
    assign o_out.found           = r_found;
    assign o_out.result_location = r_rloc;
    assign o_out.victim_page     = r_victim;

endmodule

`default_nettype wire
